/* sv/counter_array_range_sum_assert.svh */
// Assertion macros for the range-sum counter array.
// Used by the port checker; needs clk and rst in scope.
`ifndef COUNTER_ARRAY_RANGE_SUM_ASSERT_SVH
`define COUNTER_ARRAY_RANGE_SUM_ASSERT_SVH

// Check a property outside reset.
`define CRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/cra_pkg.sv */
// Shared types and constants for the range-sum counter array.
// No dependencies; imported by the cell, the sequencer and the top level.
package cra_pkg;

  localparam int SIZE       = 256;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = 8;
  localparam int TOTAL_W    = 24;
  localparam int STEP_W     = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int CMP_W      = (IDX_W > STEP_W) ? IDX_W : STEP_W;
  localparam int SUM_W      = ((TOTAL_W > COUNT_BITS) ? TOTAL_W : COUNT_BITS) + 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic CMD_INC = 1'b0;
  localparam logic CMD_SUM = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [STEP_W-1:0]     step_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [TOTAL_W-1:0]    total_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FLUSH
  } state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic shift;
    logic inc;
    idx_t inc_index;
  } cell_ctrl_t;

endpackage

/* sv/cra_cell.sv */
// One saturating counter cell of the ring.
// Depends on cra_pkg.
module cra_cell (
  input  logic                clk,
  input  logic                rst,
  input  cra_pkg::cell_ctrl_t ctrl,
  input  logic                hit,
  input  cra_pkg::count_t     prev,
  output cra_pkg::count_t     value
);
  import cra_pkg::*;

  count_t value_next;

  always_comb begin
    value_next = value;
    if (ctrl.shift) begin
      value_next = prev;
    end else if (ctrl.inc && hit && (value != {COUNT_BITS{1'b1}})) begin
      value_next = value + count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else begin
      value <= value_next;
    end
  end

endmodule

/* sv/cra_sweep.sv */
// Sequencer and accumulator: takes items, walks the ring for sum queries,
// holds the result register. Depends on cra_pkg.
module cra_sweep (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [23:0]         s_tdata,
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,
  output logic                m_tuser,
  input  cra_pkg::count_t     head,
  output cra_pkg::cell_ctrl_t ctrl
);
  import cra_pkg::*;

  state_t state, state_next;
  step_t  step;
  idx_t   lo, hi;
  total_t acc, acc_next;
  logic   err;

  idx_t   in_index, in_lo, in_hi;
  logic   accept, bound_bad, in_range, last_step, out_free, load;
  logic [SUM_W-1:0] sum;

  assign in_index = s_tdata[IDX_W-1:0];
  assign in_lo    = s_tdata[2*IDX_W-1:IDX_W];
  assign in_hi    = s_tdata[3*IDX_W-1:2*IDX_W];

  assign accept    = s_tvalid && s_tready;
  assign bound_bad = (32'(in_lo) >= 32'(SIZE)) || (32'(in_hi) >= 32'(SIZE));
  assign in_range  = (CMP_W'(step) >= CMP_W'(lo)) && (CMP_W'(step) <= CMP_W'(hi));
  assign last_step = (step == STEP_W'(SIZE - 1));
  assign out_free  = !m_tvalid || m_tready;

  // Saturating add of the counter at the ring head when its step is in range.
  assign sum      = SUM_W'(acc) + SUM_W'(in_range ? head : count_t'(0));
  assign acc_next = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    load           = 1'b0;
    ctrl.shift     = 1'b0;
    ctrl.inc       = 1'b0;
    ctrl.inc_index = in_index;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == CMD_SUM) begin
            state_next = bound_bad ? ST_FLUSH : ST_SWEEP;
          end else begin
            ctrl.inc = (32'(in_index) < 32'(SIZE));
          end
        end
      end
      ST_SWEEP: begin
        ctrl.shift = 1'b1;
        if (last_step) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (s_tuser == CMD_SUM)) begin
      lo   <= in_lo;
      hi   <= in_hi;
      step <= '0;
      acc  <= '0;
      err  <= bound_bad;
    end else if (ctrl.shift) begin
      step <= step + step_t'(1);
      acc  <= acc_next;
    end
    if (load) begin
      m_tdata <= 24'(acc);
      m_tuser <= err;
    end
  end

endmodule

/* sv/counter_array_range_sum.sv */
// Top level of the range-sum counter array: a ring of counter cells
// and the sweep sequencer. Depends on cra_pkg, cra_cell, cra_sweep.
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------
//  s_*     | in        | tuser = cmd; tdata = index, low_bound, high_bound
//  m_*     | out       | tuser = range_error; tdata = total
//
// An increment item gives no result and leaves the sequencer idle.
// A sum query rotates the ring of SIZE cells once, one counter past the
// accumulator per cycle: the query is accepted in idle, the sweep state
// shifts the ring and the flush state loads the result; then the next
// item is taken. A query with a bound outside the table skips the rotation.
// rst clears every counter and the result valid flag at once, not the data.
// A result not taken holds the sequencer before its load; increments are
// still taken while a result waits, but not while the sequencer is held.
module counter_array_range_sum (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // index [7:0], low_bound [15:8], high_bound [23:16]
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // total [23:0]
  output logic        m_tuser    // range_error
);
  import cra_pkg::*;

  count_t     ring [SIZE];
  cell_ctrl_t ctrl;

  // Sequencer: reads the counter at the head of the ring each sweep cycle.
  cra_sweep u_sweep (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .head     (ring[0]),
    .ctrl     (ctrl)
  );

  // Each cell takes the value of the next one while shifting; the last
  // closes the ring, so a full sweep leaves every counter in its home cell.
  for (genvar i = 0; i < SIZE; i++) begin : g_cell
    logic hit;
    assign hit = (32'(ctrl.inc_index) == 32'(i));
    cra_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .hit   (hit),
      .prev  (ring[(i + 1) % SIZE]),
      .value (ring[i])
    );
  end

endmodule

/* sv/cra_checker.sv */
// Port checker for the range-sum counter array, bound to the top level.
// Depends on counter_array_range_sum_assert.svh.
module cra_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);
`include "counter_array_range_sum_assert.svh"

  `CRA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `CRA_ASSERT(a_err_zero, m_tvalid && m_tuser |-> m_tdata == 24'd0, "range error with nonzero total")
  `CRA_ASSERT(a_sum_busy, s_tvalid && s_tready && s_tuser |=> !s_tready, "sum query did not start work")
  `CRA_ASSERT(a_inc_ready, s_tvalid && s_tready && !s_tuser |=> s_tready, "increment stalled input")
  `CRA_ASSERT_ALWAYS(a_rst_clear, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind counter_array_range_sum cra_checker u_cra_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
